// ===== hdl/mtwg_pkg.sv =====
// Shared constants, controller states and command/status types for the MT19937 generator.
package mtwg_pkg;

  localparam int unsigned STATE_WORDS_DEF = 624;
  localparam int unsigned SHIFT_SPAN      = 397;

  localparam logic [31:0] TWIST_CONST = 32'h9908_b0df;
  localparam logic [31:0] SEED_MULT   = 32'd1812433253;
  localparam logic [31:0] TEMPER_B    = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C    = 32'hefc6_0000;
  localparam logic [31:0] SEED_RESET  = 32'd5489;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_INIT,
    ST_SEED_MUL,
    ST_SEED_ADD,
    ST_RD_CUR,
    ST_RD_NXT,
    ST_RD_FAR,
    ST_TWIST,
    ST_OUT
  } mtwg_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic seed_init;
    logic seed_mul;
    logic seed_add;
    logic rd_cur;
    logic rd_nxt;
    logic rd_far;
    logic twist_wb;
    logic out_load;
  } mtwg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic seed_last;
    logic out_free;
  } mtwg_status_t;

endpackage

// ===== hdl/mtwg_ctrl.sv =====
// Controller state machine that sequences seeding, per-word twisting and output loading.
module mtwg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_restart,
  input  mtwg_pkg::mtwg_status_t status,
  output mtwg_pkg::mtwg_cmd_t    cmd
);
  import mtwg_pkg::*;

  mtwg_state_t state_r, state_nxt;
  logic        seeded_r, seeded_nxt;

  // State and seeded flag registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      seeded_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      seeded_r <= seeded_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt  = state_r;
    seeded_nxt = seeded_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_restart || !seeded_r) begin
            state_nxt = ST_SEED_INIT;
          end else begin
            state_nxt = ST_RD_CUR;
          end
        end
      end
      ST_SEED_INIT: begin
        state_nxt  = ST_SEED_MUL;
        seeded_nxt = 1'b1;
      end
      ST_SEED_MUL: state_nxt = ST_SEED_ADD;
      ST_SEED_ADD: begin
        if (status.seed_last) begin
          state_nxt = ST_RD_CUR;
        end else begin
          state_nxt = ST_SEED_MUL;
        end
      end
      ST_RD_CUR: state_nxt = ST_RD_NXT;
      ST_RD_NXT: state_nxt = ST_RD_FAR;
      ST_RD_FAR: state_nxt = ST_TWIST;
      ST_TWIST:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE:      in_ready      = 1'b1;
      ST_SEED_INIT: cmd.seed_init = 1'b1;
      ST_SEED_MUL:  cmd.seed_mul  = 1'b1;
      ST_SEED_ADD:  cmd.seed_add  = 1'b1;
      ST_RD_CUR:    cmd.rd_cur    = 1'b1;
      ST_RD_NXT:    cmd.rd_nxt    = 1'b1;
      ST_RD_FAR:    cmd.rd_far    = 1'b1;
      ST_TWIST:     cmd.twist_wb  = 1'b1;
      ST_OUT:       cmd.out_load  = status.out_free;
      default:      cmd           = '0;
    endcase
  end

endmodule

// ===== hdl/mtwg_dpath.sv =====
// Datapath: state memory, seed recurrence, per-word twist, tempering and output register.
module mtwg_dpath #(
  parameter int unsigned STATE_WORDS = mtwg_pkg::STATE_WORDS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [31:0]            cfg_seed_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [31:0]            out_random_word,
  input  mtwg_pkg::mtwg_cmd_t    cmd,
  output mtwg_pkg::mtwg_status_t status
);
  import mtwg_pkg::*;

  localparam int unsigned IDX_W = $clog2(STATE_WORDS);
  localparam int unsigned WRAP_AT = STATE_WORDS - SHIFT_SPAN;

  // Twist of one word from its own top bit, the next word's low bits and the far word.
  function automatic logic [31:0] twist_word(input logic [31:0] cur, input logic [31:0] nxt,
                                             input logic [31:0] far);
    logic [31:0] y;
    y = {cur[31], nxt[30:0]};
    twist_word = far ^ (y >> 1) ^ (y[0] ? TWIST_CONST : 32'h0);
  endfunction

  // Standard output tempering.
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    temper = y;
  endfunction

  logic [31:0]      mem [STATE_WORDS];
  logic [31:0]      rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_data;

  logic [31:0]      seed_r;
  logic [31:0]      prev_r;
  logic [31:0]      prod_r;
  logic [IDX_W-1:0] sidx_r;
  logic [IDX_W-1:0] k_r;
  logic [31:0]      cur_r;
  logic [31:0]      nxt_r;
  logic [31:0]      tw_r;
  logic             out_valid_r;
  logic [31:0]      out_word_r;

  logic [IDX_W-1:0] k_next;
  logic [IDX_W-1:0] k_far;
  logic [31:0]      mix;
  logic [31:0]      seed_val;
  logic [31:0]      tw_val;

  // Neighbor and far addresses, wrapping around the state.
  assign k_next = (k_r == IDX_W'(STATE_WORDS - 1)) ? '0 : k_r + IDX_W'(1);
  assign k_far  = (k_r >= IDX_W'(WRAP_AT)) ? k_r - IDX_W'(WRAP_AT) : k_r + IDX_W'(SHIFT_SPAN);

  // Seed recurrence pieces: mix before the multiply, add the index after it.
  assign mix      = prev_r ^ (prev_r >> 30);
  assign seed_val = prod_r + 32'(sidx_r);
  assign tw_val   = twist_word(cur_r, nxt_r, rd_data_r);

  // Read address and write port selection.
  always_comb begin
    rd_en   = cmd.rd_cur | cmd.rd_nxt | cmd.rd_far;
    rd_addr = k_r;
    if (cmd.rd_nxt) begin
      rd_addr = k_next;
    end else if (cmd.rd_far) begin
      rd_addr = k_far;
    end
    wr_en   = cmd.seed_init | cmd.seed_add | cmd.twist_wb;
    wr_addr = k_r;
    wr_data = tw_val;
    if (cmd.seed_init) begin
      wr_addr = '0;
      wr_data = seed_r;
    end else if (cmd.seed_add) begin
      wr_addr = sidx_r;
      wr_data = seed_val;
    end
  end

  // State memory: one write port, one registered read port that holds between reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Seed register, written from the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_valid) begin
      seed_r <= cfg_seed_value;
    end
  end

  // Seeding registers and draw position.
  always_ff @(posedge clk) begin
    if (cmd.seed_init) begin
      prev_r <= seed_r;
      sidx_r <= IDX_W'(1);
      k_r    <= '0;
    end else begin
      if (cmd.seed_add) begin
        prev_r <= seed_val;
        sidx_r <= sidx_r + IDX_W'(1);
      end
      if (cmd.out_load) begin
        k_r <= k_next;
      end
    end
    if (cmd.seed_mul) begin
      prod_r <= 32'(SEED_MULT * mix);
    end
  end

  // Operand capture for the twist.
  always_ff @(posedge clk) begin
    if (cmd.rd_nxt) begin
      cur_r <= rd_data_r;
    end
    if (cmd.rd_far) begin
      nxt_r <= rd_data_r;
    end
    if (cmd.twist_wb) begin
      tw_r <= tw_val;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_word_r <= temper(tw_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_random_word  = out_word_r;
  assign status.seed_last = (sidx_r == IDX_W'(STATE_WORDS - 1));
  assign status.out_free  = !out_valid_r || out_ready;

endmodule

// ===== hdl/mersenne_twister_word_generator.sv =====
// Top level of the MT19937 word generator: controller plus datapath.
// A draw reads the current, next and far words through the single read port of the state
// memory, writes back the twisted word and loads the output, waiting while a result stalls;
// a new request is taken only after that load. Seeding (first request after reset, or restart)
// writes word 0, then each further word by a registered multiply and an add of the index.
// Reset clears control state and sets the seed to 5489; the state memory is unset until seeded.
module mersenne_twister_word_generator #(
  parameter int unsigned STATE_WORDS = mtwg_pkg::STATE_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_random_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_seed_value
);
  import mtwg_pkg::*;

  mtwg_cmd_t    cmd;
  mtwg_status_t status;

  // The seed register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  mtwg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .status     (status),
    .cmd        (cmd)
  );

  mtwg_dpath #(
    .STATE_WORDS (STATE_WORDS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_seed_value  (cfg_seed_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_word (out_random_word),
    .cmd             (cmd),
    .status          (status)
  );

endmodule

// ===== hdl/mtwg_checker.sv =====
// Port-level checker for the MT19937 word generator and its bind to the top level.
module mtwg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_random_word,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // No result is offered in the cycle after a reset.
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_random_word))
    else $error("stalled result changed");

  // A taken request keeps the block busy in the next cycle.
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one is still in work");

  // The seed register never blocks a write.
  a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("seed write stalled");

endmodule

bind mersenne_twister_word_generator mtwg_checker u_mtwg_checker (.*);

// ===== tb/mersenne_twister_word_generator_test.sv =====
// Self-checking testbench for the MT19937 word generator with a word scoreboard.
module mersenne_twister_word_generator_test;
  import mtwg_pkg::*;

  localparam int unsigned WORDS      = STATE_WORDS_DEF;
  localparam int unsigned UNSEEDED   = WORDS + 1;
  localparam logic [31:0] HIGH_BIT   = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS   = 32'h7fff_ffff;

  // Tracks the generator state and holds the tempered words still to come back.
  class word_board;
    logic [31:0] mt [WORDS];
    int unsigned next_pos;
    logic [31:0] seed;
    logic [31:0] pending_words [$];
    int unsigned requests, reseeds, words_checked, seeds_loaded, failures;

    function new();
      next_pos = UNSEEDED;
      seed = SEED_RESET;
      foreach (mt[i]) mt[i] = '0;
    endfunction

    // Fill the state from the seed with the multiplier recurrence.
    function void reseed();
      logic [31:0] prev;
      mt[0] = seed;
      for (int i = 1; i < WORDS; i++) begin
        prev = mt[i - 1];
        mt[i] = SEED_MULT * (prev ^ (prev >> 30)) + 32'(i);
      end
      next_pos = WORDS;
    endfunction

    // Twist the whole state in place.
    function void twist();
      logic [31:0] y, v;
      for (int k = 0; k < WORDS; k++) begin
        y = (mt[k] & HIGH_BIT) | (mt[(k + 1) % WORDS] & LOW_BITS);
        v = mt[(k + SHIFT_SPAN) % WORDS] ^ (y >> 1);
        if (y[0]) v ^= TWIST_CONST;
        mt[k] = v;
      end
      next_pos = 0;
    endfunction

    function logic [31:0] temper(logic [31:0] w);
      logic [31:0] y;
      y = w;
      y ^= y >> 11;
      y ^= (y << 7) & TEMPER_B;
      y ^= (y << 15) & TEMPER_C;
      y ^= y >> 18;
      return y;
    endfunction

    // A new seed only matters at the next seeding.
    function void load_seed(logic [31:0] value);
      seed = value;
      seeds_loaded++;
    endfunction

    function void note_request(logic restart);
      requests++;
      if (restart) reseeds++;
      if (restart || next_pos > WORDS) reseed();
      if (next_pos >= WORDS) twist();
      pending_words.push_back(temper(mt[next_pos]));
      next_pos++;
    endfunction

    function void check_word(logic [31:0] got);
      logic [31:0] want;
      words_checked++;
      if (pending_words.size() == 0) begin
        failures++;
        if (failures <= 10) $display("Unexpected word %h with nothing pending.", got);
        return;
      end
      want = pending_words.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10)
          $display("Word %0d: expected %h, got %h.", words_checked, want, got);
      end
    endfunction

    function void close_out();
      if (pending_words.size() != 0) begin
        failures++;
        $display("%0d expected words never arrived.", pending_words.size());
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [31:0] out_random_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_seed_value = '0;

  bit calm = 1'b0;
  word_board board = new();

  mersenne_twister_word_generator uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_random_word(out_random_word),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_seed_value (cfg_seed_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch every handshake; requests are noted before results are checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.load_seed(cfg_seed_value);
      if (in_valid && in_ready) board.note_request(in_restart);
      if (out_valid && out_ready) board.check_word(out_random_word);
    end
  end

  // Receiver stalls in random bursts, none once the run is calm.
  initial begin
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Present one request, sometimes after a random gap, and wait for its acceptance.
  task automatic send_request(input logic restart);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_seed_value <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop requesting and wait until every expected word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_words.size() != 0) @(posedge clk);
  endtask

  // One random phase: a fresh seed, then a stream of draws with occasional restarts.
  task automatic run_phase(input int unsigned count, input int unsigned restart_odds,
                           input bit quiet);
    drain();
    calm = quiet;
    write_seed($urandom());
    for (int unsigned n = 0; n < count; n++) begin
      if (n == 0) send_request(1'($urandom_range(0, 1)));
      else send_request(restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Default seed: the first request seeds, then a restart on a running sequence.
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    // Extreme seeds.
    drain();
    write_seed(32'h0000_0000);
    send_request(1'b1);
    send_request(1'b0);
    drain();
    write_seed(32'hffff_ffff);
    send_request(1'b1);
    send_request(1'b0);
    // A new seed must not disturb the running sequence until a restart.
    drain();
    write_seed(32'h8000_0000);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b1);
    drain();
    write_seed(32'h0000_0001);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);

    // Long run across the twist boundary, then phases with restarts.
    run_phase(700, 0, 1'b0);
    run_phase(300, 30, 1'b0);
    run_phase(300, 100, 1'b1);

    drain();
    repeat (20) @(posedge clk);
    board.close_out();
    $display("Run covered %0d requests with %0d restarts and %0d seed writes.",
             board.requests, board.reseeds, board.seeds_loaded);
    $display("%0d words checked, %0d failures.", board.words_checked, board.failures);
    if (board.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Timeout with %0d words pending.", board.pending_words.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== mersenne_twister_word_generator.f =====
hdl/mtwg_pkg.sv
hdl/mtwg_ctrl.sv
hdl/mtwg_dpath.sv
hdl/mersenne_twister_word_generator.sv
hdl/mtwg_checker.sv
tb/mersenne_twister_word_generator_test.sv
